FILE: hw/rtl/rrct_pkg.sv
// shared constants, types and the sine table generator for the box collision block
package rrct_pkg;

    localparam int EXT_W         = 24;
    localparam int NUM_REGS      = 8;
    localparam int IDX_W         = 3;
    localparam int ANG_W         = 10;
    localparam int CORNER_W      = 27;
    localparam int SQ_W          = 48;
    localparam int RAD_W         = 24;
    localparam int RSQ_W         = 50;
    localparam int SINE_BITS_DEF = 10;

    // query modes
    localparam logic [1:0] MODE_BOX   = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_AXIS  = 2'd2;

    // register indexes, box b starts at b * REGS_PER_BOX
    localparam int REG_XMIN     = 0;
    localparam int REG_XMAX     = 1;
    localparam int REG_YMIN     = 2;
    localparam int REG_YMAX     = 3;
    localparam int REGS_PER_BOX = 4;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic signed [EXT_W-1:0] t_ext;

    typedef struct packed {
        logic             busy;
        logic [1:0]       empty;
        logic [SQ_W-1:0]  sq_rad_a;
        logic [RSQ_W-1:0] rs_sq;
    } t_cfg_st;

    // quotient by shift and subtract, only used while the table is built
    function automatic longint unsigned div_small(input longint unsigned n,
                                                  input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = (r << 1) | ((n >> i) & 64'd1);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // sin(2*pi*q/1024) for a quarter wave, rounded to q1.bits
    function automatic longint quarter_sine(input int unsigned q, input int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          s;
        x    = (longint'(q) * PI_Q30 + 64'd256) >> 9;
        x2   = (x * x) >> 30;
        term = x;
        s    = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            term = div_small((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        return (s + (longint'(1) << (29 - bits))) >>> (30 - bits);
    endfunction

endpackage

FILE: hw/rtl/rrct_query_if.sv
// query channel: mode, two box poses
interface rrct_query_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         mode;
    logic signed [rrct_pkg::EXT_W-1:0]  pos_a_x;
    logic signed [rrct_pkg::EXT_W-1:0]  pos_a_y;
    logic [rrct_pkg::ANG_W-1:0]         angle_a;
    logic signed [rrct_pkg::EXT_W-1:0]  pos_b_x;
    logic signed [rrct_pkg::EXT_W-1:0]  pos_b_y;
    logic [rrct_pkg::ANG_W-1:0]         angle_b;

    modport source (output valid, mode, pos_a_x, pos_a_y, angle_a, pos_b_x, pos_b_y, angle_b,
                    input ready);
    modport sink (input valid, mode, pos_a_x, pos_a_y, angle_a, pos_b_x, pos_b_y, angle_b,
                  output ready);
endinterface

FILE: hw/rtl/rrct_result_if.sv
// result channel: one hit bit per item
interface rrct_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

FILE: hw/rtl/rrct_cfg.sv
// extent registers and derived radii, recomputed by a bit-serial square root
module rrct_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [rrct_pkg::IDX_W-1:0]    i_idx,
    input  logic [rrct_pkg::EXT_W-1:0]    i_data,
    output rrct_pkg::t_ext                o_ext [rrct_pkg::NUM_REGS],
    output rrct_pkg::t_cfg_st             o_st
);

    localparam int SQ_W  = rrct_pkg::SQ_W;
    localparam int RAD_W = rrct_pkg::RAD_W;
    localparam int REM_W = RAD_W + 2;
    localparam int RS_W  = RAD_W + 1;
    localparam int RPB   = rrct_pkg::REGS_PER_BOX;

    localparam logic [4:0] ST_SQ        = 5'd0;
    localparam logic [4:0] ST_LOAD      = 5'd1;
    localparam logic [4:0] ST_ITER_LAST = 5'd25;
    localparam logic [4:0] ST_CEIL      = 5'd26;
    localparam logic [4:0] ST_RS        = 5'd27;

    rrct_pkg::t_ext         r_ext [rrct_pkg::NUM_REGS];
    logic                   r_busy;
    logic [4:0]             r_step;
    logic [SQ_W-1:0]        r_sqx [2];
    logic [SQ_W-1:0]        r_sqy [2];
    logic [SQ_W-1:0]        r_n [2];
    logic [REM_W-1:0]       r_rem [2];
    logic [RAD_W-1:0]       r_root [2];
    logic [RAD_W-1:0]       r_rad [2];
    logic [SQ_W-1:0]        r_sq_a;
    logic [rrct_pkg::RSQ_W-1:0] r_rs_sq;

    logic [RAD_W-1:0]       w_tx [2];
    logic [RAD_W-1:0]       w_ty [2];
    logic [REM_W-1:0]       w_remx [2];
    logic [REM_W-1:0]       w_trial [2];
    logic [RS_W-1:0]        w_rs;
    logic [1:0]             w_empty;

    function automatic logic [RAD_W-1:0] abs_u(input rrct_pkg::t_ext v);
        return v[RAD_W-1] ? RAD_W'(-v) : RAD_W'(v);
    endfunction

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            w_tx[b] = (abs_u(r_ext[b*RPB + rrct_pkg::REG_XMIN]) >
                       abs_u(r_ext[b*RPB + rrct_pkg::REG_XMAX]))
                    ? abs_u(r_ext[b*RPB + rrct_pkg::REG_XMIN])
                    : abs_u(r_ext[b*RPB + rrct_pkg::REG_XMAX]);
            w_ty[b] = (abs_u(r_ext[b*RPB + rrct_pkg::REG_YMIN]) >
                       abs_u(r_ext[b*RPB + rrct_pkg::REG_YMAX]))
                    ? abs_u(r_ext[b*RPB + rrct_pkg::REG_YMIN])
                    : abs_u(r_ext[b*RPB + rrct_pkg::REG_YMAX]);
            w_remx[b]  = {r_rem[b][REM_W-3:0], r_n[b][SQ_W-1 -: 2]};
            w_trial[b] = {r_root[b], 2'b01};
            w_empty[b] = !((r_ext[b*RPB + rrct_pkg::REG_XMIN] !=
                            r_ext[b*RPB + rrct_pkg::REG_XMAX]) &&
                           (r_ext[b*RPB + rrct_pkg::REG_YMIN] !=
                            r_ext[b*RPB + rrct_pkg::REG_YMAX]));
        end
        w_rs = {1'b0, r_rad[0]} + {1'b0, r_rad[1]};
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rrct_pkg::NUM_REGS; i++) begin
                r_ext[i] <= '0;
            end
            r_busy  <= 1'b0;
            r_step  <= ST_SQ;
            r_rad[0] <= '0;
            r_rad[1] <= '0;
            r_sq_a  <= '0;
            r_rs_sq <= '0;
        end else if (i_we) begin
            r_ext[i_idx] <= i_data;
            r_busy       <= 1'b1;
            r_step       <= ST_SQ;
        end else if (r_busy) begin
            r_step <= r_step + 5'd1;
            if (r_step == ST_LOAD) begin
                r_sq_a <= r_sqx[0] + r_sqy[0];
            end
            if (r_step == ST_CEIL) begin
                for (int b = 0; b < 2; b++) begin
                    r_rad[b] <= r_root[b] + RAD_W'(r_rem[b] != '0);
                end
            end
            if (r_step == ST_RS) begin
                r_rs_sq <= w_rs * w_rs;
                r_busy  <= 1'b0;
            end
        end
    end

    // squares and one root digit per cycle
    always_ff @(posedge i_clk) begin
        if (r_busy && !i_we) begin
            for (int b = 0; b < 2; b++) begin
                if (r_step == ST_SQ) begin
                    r_sqx[b] <= w_tx[b] * w_tx[b];
                    r_sqy[b] <= w_ty[b] * w_ty[b];
                end
                if (r_step == ST_LOAD) begin
                    r_n[b]    <= r_sqx[b] + r_sqy[b];
                    r_rem[b]  <= '0;
                    r_root[b] <= '0;
                end
                if (r_step > ST_LOAD && r_step <= ST_ITER_LAST) begin
                    r_n[b] <= {r_n[b][SQ_W-3:0], 2'b00};
                    if (w_remx[b] >= w_trial[b]) begin
                        r_rem[b]  <= w_remx[b] - w_trial[b];
                        r_root[b] <= {r_root[b][RAD_W-2:0], 1'b1};
                    end else begin
                        r_rem[b]  <= w_remx[b];
                        r_root[b] <= {r_root[b][RAD_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_ext          = r_ext;
    assign o_st.busy      = r_busy;
    assign o_st.empty     = w_empty;
    assign o_st.sq_rad_a  = r_sq_a;
    assign o_st.rs_sq     = r_rs_sq;

    a_we_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_we |=> (r_busy && r_step == ST_SQ))
        else $error("config write did not start recompute");

    a_rs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_rs_sq >= {2'b00, r_sq_a}))
        else $error("circle radius sum below box a radius");

    a_seq_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_we && r_step == ST_RS) |=> !r_busy)
        else $error("recompute did not finish");

endmodule

FILE: hw/rtl/rotated_rect_collision_test.sv
// top level: eight-stage pipelined oriented box overlap test, one item per cycle when not stalled
// an accepted item passes through eight register stages before its result is valid
// throughput: one item per cycle unless the output stalls or the radii are recomputed; stages
// close up behind a stalled output, so items keep flowing until all eight stages hold one
// a configuration write recomputes the box radii, input ready is low meanwhile
// reset (synchronous, active low) empties the pipeline, clears all extents and radii
module rotated_rect_collision_test #(
    parameter int SINE_TABLE_BITS = rrct_pkg::SINE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rrct_query_if.sink                  i_q,
    rrct_result_if.source               o_r,
    input  logic                        i_cfg_we,
    input  logic [rrct_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [rrct_pkg::EXT_W-1:0]  i_cfg_data
);

    // widths; the trig and product widths follow from the sine precision
    localparam int STB = SINE_TABLE_BITS;
    localparam int EW  = rrct_pkg::EXT_W;
    localparam int QW  = STB + 1;           // table magnitude
    localparam int SW  = STB + 2;           // signed sine / cosine
    localparam int PW  = EW + SW;           // extent times sine
    localparam int VW  = PW + 2;            // rotated sum with rounding headroom
    localparam int CW  = rrct_pkg::CORNER_W;
    localparam int DW  = CW + 1;            // edge delta
    localparam int XW  = CW + 2;            // sum of four corners
    localparam int UW  = CW + 3;            // point minus scaled vertex
    localparam int MW  = DW + UW;           // edge value product
    localparam int DDW = EW + 1;            // centre distance per axis
    localparam int DSW = 2 * DDW;
    localparam int RW  = rrct_pkg::RSQ_W;
    localparam int NST = 8;
    localparam int NPT = 6;                 // points per box: five tested plus own centre
    localparam int RPB = rrct_pkg::REGS_PER_BOX;
    localparam int TAB = 257;
    localparam logic signed [VW-1:0] HALF = VW'(1) <<< (STB - 1);

    // configuration and derived radii
    rrct_pkg::t_ext    w_ext [rrct_pkg::NUM_REGS];
    rrct_pkg::t_cfg_st w_st;

    rrct_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_ext  (w_ext),
        .o_st   (w_st)
    );

    // quarter-wave sine table, built at elaboration
    logic [QW-1:0] w_qs [TAB];
    for (genvar g = 0; g < TAB; g++) begin : g_tab
        localparam logic [QW-1:0] QS_VAL = QW'(rrct_pkg::quarter_sine(g, STB));
        assign w_qs[g] = QS_VAL;
    end

    // flow control: a stage loads when it is empty or its successor moves
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || o_r.ready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    assign i_q.ready = w_en[0] && !w_st.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_q.valid && !w_st.busy;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // ---------------- stage 1: sine / cosine lookup, centre distance per axis
    // trig order: sin a, cos a, sin b, cos b; cosine is sine a quarter turn on
    logic [rrct_pkg::ANG_W-1:0] w_ang [4];
    logic [8:0]                 w_tidx [4];
    logic signed [SW-1:0]       w_mag [4];
    logic signed [SW-1:0]       w_trig [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_ang[l] = ((l < 2) ? i_q.angle_a : i_q.angle_b) +
                       ((l == 1 || l == 3) ? 10'd256 : 10'd0);
            // odd quadrants run the table backwards, upper half negates
            w_tidx[l] = w_ang[l][8] ? (9'd256 - {1'b0, w_ang[l][7:0]})
                                    : {1'b0, w_ang[l][7:0]};
            w_mag[l]  = signed'({1'b0, w_qs[w_tidx[l]]});
            w_trig[l] = w_ang[l][9] ? -w_mag[l] : w_mag[l];
        end
    end

    logic [1:0]            r1_mode;
    logic signed [EW-1:0]  r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [SW-1:0]  r1_trig [4];
    logic signed [DDW-1:0] r1_ddx, r1_ddy;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_mode <= i_q.mode;
            r1_ax   <= i_q.pos_a_x;
            r1_ay   <= i_q.pos_a_y;
            r1_bx   <= i_q.pos_b_x;
            r1_by   <= i_q.pos_b_y;
            r1_trig <= w_trig;
            r1_ddx  <= DDW'(i_q.pos_a_x) - DDW'(i_q.pos_b_x);
            r1_ddy  <= DDW'(i_q.pos_a_y) - DDW'(i_q.pos_b_y);
        end
    end

    // ---------------- stage 2: extent products, squared distance terms
    // index e selects min (0) or max (1) of an axis
    logic [1:0]            r2_mode;
    logic signed [EW-1:0]  r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [PW-1:0]  r2_xc [2][2];
    logic signed [PW-1:0]  r2_xs [2][2];
    logic signed [PW-1:0]  r2_yc [2][2];
    logic signed [PW-1:0]  r2_ys [2][2];
    logic signed [DSW-1:0] w_sqx, w_sqy;
    logic [DSW-2:0]        r2_sqx, r2_sqy;

    assign w_sqx = r1_ddx * r1_ddx;
    assign w_sqy = r1_ddy * r1_ddy;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_mode <= r1_mode;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_sqx  <= w_sqx[DSW-2:0];
            r2_sqy  <= w_sqy[DSW-2:0];
            for (int b = 0; b < 2; b++) begin
                for (int e = 0; e < 2; e++) begin
                    r2_xc[b][e] <= w_ext[b*RPB + rrct_pkg::REG_XMIN + e] * r1_trig[2*b+1];
                    r2_xs[b][e] <= w_ext[b*RPB + rrct_pkg::REG_XMIN + e] * r1_trig[2*b];
                    r2_yc[b][e] <= w_ext[b*RPB + rrct_pkg::REG_YMIN + e] * r1_trig[2*b+1];
                    r2_ys[b][e] <= w_ext[b*RPB + rrct_pkg::REG_YMIN + e] * r1_trig[2*b];
                end
            end
        end
    end

    // ---------------- stage 3: rounded corners, circle prefilters
    // corner order: (xmin,ymin) (xmax,ymin) (xmax,ymax) (xmin,ymax)
    logic signed [VW-1:0] w_vx [2][4];
    logic signed [VW-1:0] w_vy [2][4];
    logic signed [VW-1:0] w_rx [2][4];
    logic signed [VW-1:0] w_ry [2][4];
    logic signed [CW-1:0] w_cx [2][4];
    logic signed [CW-1:0] w_cy [2][4];
    logic [RW-1:0]        w_d;

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < 4; i++) begin
                w_vx[b][i] = VW'(r2_xc[b][(i == 1 || i == 2) ? 1 : 0]) -
                             VW'(r2_ys[b][(i >= 2) ? 1 : 0]);
                w_vy[b][i] = VW'(r2_xs[b][(i == 1 || i == 2) ? 1 : 0]) +
                             VW'(r2_yc[b][(i >= 2) ? 1 : 0]);
                // round half up, floor shift
                w_rx[b][i] = (w_vx[b][i] + HALF) >>> STB;
                w_ry[b][i] = (w_vy[b][i] + HALF) >>> STB;
                w_cx[b][i] = w_rx[b][i][CW-1:0] + CW'((b == 0) ? r2_ax : r2_bx);
                w_cy[b][i] = w_ry[b][i][CW-1:0] + CW'((b == 0) ? r2_ay : r2_by);
            end
        end
        // point mode: the test point takes the place of box b's first corner
        if (r2_mode == rrct_pkg::MODE_POINT) begin
            w_cx[1][0] = CW'(r2_bx);
            w_cy[1][0] = CW'(r2_by);
        end
        w_d = {1'b0, r2_sqx} + {1'b0, r2_sqy};
    end

    logic [1:0]           r3_mode;
    logic                 r3_f0, r3_f1;
    logic signed [CW-1:0] r3_cx [2][4];
    logic signed [CW-1:0] r3_cy [2][4];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_mode <= r2_mode;
            r3_cx   <= w_cx;
            r3_cy   <= w_cy;
            r3_f0   <= w_st.rs_sq > w_d;
            r3_f1   <= RW'(w_st.sq_rad_a) >= w_d;
        end
    end

    // ---------------- stage 4: centre sums and edge deltas
    logic [1:0]           r4_mode;
    logic                 r4_f0, r4_f1;
    logic signed [CW-1:0] r4_cx [2][4];
    logic signed [CW-1:0] r4_cy [2][4];
    logic signed [XW-1:0] r4_sx [2];
    logic signed [XW-1:0] r4_sy [2];
    logic signed [DW-1:0] r4_dx [2][4];
    logic signed [DW-1:0] r4_dy [2][4];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_mode <= r3_mode;
            r4_f0   <= r3_f0;
            r4_f1   <= r3_f1;
            r4_cx   <= r3_cx;
            r4_cy   <= r3_cy;
            for (int b = 0; b < 2; b++) begin
                r4_sx[b] <= XW'(r3_cx[b][0]) + XW'(r3_cx[b][1]) +
                            XW'(r3_cx[b][2]) + XW'(r3_cx[b][3]);
                r4_sy[b] <= XW'(r3_cy[b][0]) + XW'(r3_cy[b][1]) +
                            XW'(r3_cy[b][2]) + XW'(r3_cy[b][3]);
                for (int j = 0; j < 4; j++) begin
                    r4_dx[b][j] <= DW'(r3_cx[b][(j == 3) ? 0 : j + 1]) - DW'(r3_cx[b][j]);
                    r4_dy[b][j] <= DW'(r3_cy[b][(j == 3) ? 0 : j + 1]) - DW'(r3_cy[b][j]);
                end
            end
        end
    end

    // ---------------- stage 5: point offsets from each edge start
    // points against box b: the other box's corners, its centre, own centre
    // centres carry four times the scale, so the vertex is scaled to match
    logic [1:0]           r5_mode;
    logic                 r5_f0, r5_f1;
    logic signed [DW-1:0] r5_dx [2][4];
    logic signed [DW-1:0] r5_dy [2][4];
    logic signed [UW-1:0] r5_ux [2][NPT][4];
    logic signed [UW-1:0] r5_uy [2][NPT][4];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_mode <= r4_mode;
            r5_f0   <= r4_f0;
            r5_f1   <= r4_f1;
            r5_dx   <= r4_dx;
            r5_dy   <= r4_dy;
            for (int b = 0; b < 2; b++) begin
                for (int j = 0; j < 4; j++) begin
                    for (int p = 0; p < 4; p++) begin
                        r5_ux[b][p][j] <= UW'(r4_cx[1-b][p]) - UW'(r4_cx[b][j]);
                        r5_uy[b][p][j] <= UW'(r4_cy[1-b][p]) - UW'(r4_cy[b][j]);
                    end
                    r5_ux[b][4][j] <= UW'(r4_sx[1-b]) - (UW'(r4_cx[b][j]) <<< 2);
                    r5_uy[b][4][j] <= UW'(r4_sy[1-b]) - (UW'(r4_cy[b][j]) <<< 2);
                    r5_ux[b][5][j] <= UW'(r4_sx[b]) - (UW'(r4_cx[b][j]) <<< 2);
                    r5_uy[b][5][j] <= UW'(r4_sy[b]) - (UW'(r4_cy[b][j]) <<< 2);
                end
            end
        end
    end

    // ---------------- stage 6: edge value products
    logic [1:0]           r6_mode;
    logic                 r6_f0, r6_f1;
    logic signed [MW-1:0] r6_m1 [2][NPT][4];
    logic signed [MW-1:0] r6_m2 [2][NPT][4];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_mode <= r5_mode;
            r6_f0   <= r5_f0;
            r6_f1   <= r5_f1;
            for (int b = 0; b < 2; b++) begin
                for (int p = 0; p < NPT; p++) begin
                    for (int j = 0; j < 4; j++) begin
                        r6_m1[b][p][j] <= r5_dy[b][j] * r5_ux[b][p][j];
                        r6_m2[b][p][j] <= r5_dx[b][j] * r5_uy[b][p][j];
                    end
                end
            end
        end
    end

    // ---------------- stage 7: edge value signs
    logic [1:0] r7_mode;
    logic       r7_f0, r7_f1;
    logic       r7_pos [2][NPT][4];
    logic       r7_neg [2][NPT][4];

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_mode <= r6_mode;
            r7_f0   <= r6_f0;
            r7_f1   <= r6_f1;
            for (int b = 0; b < 2; b++) begin
                for (int p = 0; p < NPT; p++) begin
                    for (int j = 0; j < 4; j++) begin
                        r7_pos[b][p][j] <= r6_m1[b][p][j] > r6_m2[b][p][j];
                        r7_neg[b][p][j] <= r6_m1[b][p][j] < r6_m2[b][p][j];
                    end
                end
            end
        end
    end

    // ---------------- stage 8: inside tests, mode select, output register
    // a point is outside when some edge sign is strictly opposite to the centre's
    logic       w_ins [2][5];
    logic       w_any;
    logic       w_axis;
    logic       w_hit;
    logic       r8_hit;

    always_comb begin
        w_any = 1'b0;
        for (int b = 0; b < 2; b++) begin
            for (int p = 0; p < 5; p++) begin
                w_ins[b][p] = 1'b1;
                for (int j = 0; j < 4; j++) begin
                    if ((r7_pos[b][5][j] && r7_neg[b][p][j]) ||
                        (r7_neg[b][5][j] && r7_pos[b][p][j])) begin
                        w_ins[b][p] = 1'b0;
                    end
                end
                w_any = w_any || w_ins[b][p];
            end
        end
        // strict overlap of the raw extents on both axes
        w_axis = (w_ext[rrct_pkg::REG_XMAX] > w_ext[RPB + rrct_pkg::REG_XMIN]) &&
                 (w_ext[rrct_pkg::REG_XMIN] < w_ext[RPB + rrct_pkg::REG_XMAX]) &&
                 (w_ext[rrct_pkg::REG_YMAX] > w_ext[RPB + rrct_pkg::REG_YMIN]) &&
                 (w_ext[rrct_pkg::REG_YMIN] < w_ext[RPB + rrct_pkg::REG_YMAX]);
        unique case (r7_mode)
            rrct_pkg::MODE_BOX:   w_hit = (w_st.empty == 2'b00) && r7_f0 && w_any;
            rrct_pkg::MODE_POINT: w_hit = !w_st.empty[0] && r7_f1 && w_ins[0][0];
            rrct_pkg::MODE_AXIS:  w_hit = (w_st.empty == 2'b00) && w_axis;
            default:              w_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r8_hit <= w_hit;
        end
    end

    assign o_r.valid = r_v[NST-1];
    assign o_r.hit   = r8_hit;

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.busy |-> !i_q.ready)
        else $error("item accepted during radius recompute");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q.valid && i_q.ready) |=> r_v[0])
        else $error("accepted item missing from first stage");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-2] && !w_en[NST-2]) |=> r_v[NST-2])
        else $error("stalled item dropped");

    a_empty_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NST-1] |-> (i_q.ready == !w_st.busy))
        else $error("pipeline stalled with empty output");

endmodule
